// File: hdl/word_clock_led_mask_encoder_macros.svh
// ---------------------------------------------------------------------------
// Word clock LED mask encoder - assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset.
// ---------------------------------------------------------------------------
`ifndef WORD_CLOCK_LED_MASK_ENCODER_MACROS_SVH
`define WORD_CLOCK_LED_MASK_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wcl same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wcl next-cycle check failed");

`endif

// File: hdl/wcl_pkg.sv
// ---------------------------------------------------------------------------
// wcl_pkg
// Word LED masks, time constants and decode functions for the word clock.
// ---------------------------------------------------------------------------
package wcl_pkg;

	// Time constants
	localparam logic [4:0] HOURS_PER_DAY  = 5'd24;
	localparam logic [4:0] HOURS_PER_DIAL = 5'd12;
	localparam logic [4:0] LAST_HOUR      = 5'd23;
	localparam logic [5:0] MINUTE_MAX     = 6'd59;
	localparam logic [5:0] MINUTES_HOUR   = 6'd60;
	localparam logic [5:0] HALF_HOUR      = 6'd30;
	localparam logic [5:0] ROUND_BIAS     = 6'd2;
	localparam logic [5:0] MINUTE_STEP    = 6'd5;

	// Divide by five: x * 205 >> 10, exact for the small range used here
	localparam int          RECIP_SHIFT = 10;
	localparam logic [13:0] RECIP_FIVE  = 14'd205;

	// Word masks
	localparam logic [63:0] M_ITIS    = 64'hC000_0000_0000_0000;
	localparam logic [63:0] M_HALF    = 64'h1800_0000_0000_0000;
	localparam logic [63:0] M_TENMIN  = 64'h0300_0000_0000_0000;
	localparam logic [63:0] M_QUARTER = 64'h000F_0000_0000_0000;
	localparam logic [63:0] M_TWENTY  = 64'h00F0_0000_0000_0000;
	localparam logic [63:0] M_FIVEMIN = 64'h0000_C000_0000_0000;
	localparam logic [63:0] M_TO      = 64'h0000_0100_0000_0000;
	localparam logic [63:0] M_PAST    = 64'h0000_0003_0000_0000;
	localparam logic [63:0] M_OCLOCK  = 64'h0000_0000_0000_00F0;

	// Hour word on the 12-hour dial (index 0 reads TWELVE)
	function automatic logic [63:0] hour_word(input logic [3:0] dial);
		logic [63:0] w;
		unique case (dial)
			4'd0:    w = 64'h0000_0000_0000_0007; // TWELVE
			4'd1:    w = 64'h0000_0018_0000_0000; // ONE
			4'd2:    w = 64'h0000_0000_C000_0000; // TWO
			4'd3:    w = 64'h0000_00E0_0000_0000; // THREE
			4'd4:    w = 64'h0000_0000_1800_0000; // FOUR
			4'd5:    w = 64'h0000_0000_0300_0000; // FIVE
			4'd6:    w = 64'h0000_0000_0003_0000; // SIX
			4'd7:    w = 64'h0000_0000_001C_0000; // SEVEN
			4'd8:    w = 64'h0000_0000_00E0_0000; // EIGHT
			4'd9:    w = 64'h0000_0000_0000_C000; // NINE
			4'd10:   w = 64'h0000_0000_0000_2000; // TEN
			4'd11:   w = 64'h0000_0000_0000_0700; // ELEVEN
			default: w = '0;
		endcase
		return w;
	endfunction

	// Minute word for a distance from the full hour
	function automatic logic [63:0] minute_word(input logic [4:0] gap);
		logic [63:0] w;
		case (gap)
			5'd5:    w = M_FIVEMIN;
			5'd10:   w = M_TENMIN;
			5'd15:   w = M_QUARTER;
			5'd20:   w = M_TWENTY;
			5'd25:   w = M_TWENTY | M_FIVEMIN;
			5'd30:   w = M_HALF;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: hdl/wcl_round.sv
// ---------------------------------------------------------------------------
// wcl_round
// Range fixup and round-to-five of the time, with rollover into next hour.
// ---------------------------------------------------------------------------
module wcl_round
	import wcl_pkg::*;
(
	input  logic [4:0] hour_raw,
	input  logic [5:0] minute_raw,
	output logic [4:0] hour,
	output logic [5:0] minute
);

	logic [4:0]  hour_n;
	logic [5:0]  minute_n;
	logic [13:0] prod;
	logic [3:0]  quot;
	logic [5:0]  rounded;
	logic        rollover;

	// Wrap hours past the day, clamp minutes past the hour
	assign hour_n   = (hour_raw >= HOURS_PER_DAY) ? hour_raw - HOURS_PER_DAY : hour_raw;
	assign minute_n = (minute_raw > MINUTE_MAX) ? MINUTE_MAX : minute_raw;

	// (m + 2) / 5 by reciprocal multiply, then back to minutes
	assign prod     = 14'(minute_n + ROUND_BIAS) * RECIP_FIVE;
	assign quot     = prod[RECIP_SHIFT +: 4];
	assign rounded  = 6'(quot) * MINUTE_STEP;
	assign rollover = (rounded == MINUTES_HOUR);

	// A rounded 60 becomes 0 of the next hour
	assign minute = rollover ? 6'd0 : rounded;
	assign hour   = !rollover ? hour_n : ((hour_n == LAST_HOUR) ? 5'd0 : hour_n + 5'd1);

endmodule

// File: hdl/wcl_mask.sv
// ---------------------------------------------------------------------------
// wcl_mask
// Builds the 64-bit LED mask from a rounded 24-hour time.
// ---------------------------------------------------------------------------
module wcl_mask
	import wcl_pkg::*;
(
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	output logic [63:0] led_mask
);

	logic        past;
	logic [4:0]  min_gap;
	logic [4:0]  dial_hour;
	logic [4:0]  dial_full;
	logic [63:0] min_bits;

	// Up to half past reads PAST, beyond that TO with the next hour
	assign past      = (minute <= HALF_HOUR);
	assign min_gap   = past ? minute[4:0] : 5'(MINUTES_HOUR - minute);
	assign dial_hour = past ? hour : ((hour == LAST_HOUR) ? 5'd0 : hour + 5'd1);
	assign dial_full = (dial_hour >= HOURS_PER_DIAL) ? dial_hour - HOURS_PER_DIAL : dial_hour;

	// Minute phrase
	always_comb begin
		if (minute == 6'd0) begin
			min_bits = M_OCLOCK;
		end else if (past) begin
			min_bits = M_PAST | minute_word(min_gap);
		end else begin
			min_bits = M_TO | minute_word(min_gap);
		end
	end

	assign led_mask = M_ITIS | min_bits | hour_word(dial_full[3:0]);

endmodule

// File: hdl/word_clock_led_mask_encoder.sv
// ---------------------------------------------------------------------------
// Word clock LED mask encoder.
// Input stream s_axis carries a 24-hour time, output stream m_axis carries
// the LED mask of an 8x8 word-clock matrix with the rounded time shown.
// The minute is rounded to the nearest five; a rounded 60 rolls into the
// next hour. A frame goes out only when the rounded time differs from the
// last frame sent; items that change nothing are absorbed without output.
// A beat passes the input register, then the output register, to m_axis.
// Throughput: one beat per cycle while m_axis does not stall, set by the
// single rounding/decode path between the input and output registers.
// Reset (arst_n low) empties both registers and clears the last-shown time,
// so the first beat after reset always produces a frame.
// When m_axis stalls the output register holds its frame and the input
// register can still take one more beat; s_axis_tready then drops until
// the output frame is taken.
// ---------------------------------------------------------------------------
`include "word_clock_led_mask_encoder_macros.svh"

module word_clock_led_mask_encoder
	import wcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [4:0] hour_of_day, [10:5] minute_of_hour, rest 0
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // [63:0] led_mask, [68:64] shown_hour,
	                                   // [74:69] shown_minute, rest 0
);

	logic        s1_valid_q;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [4:0]  hour_r;
	logic [5:0]  minute_r;
	logic [63:0] mask_r;
	logic        emit;
	logic        out_free;
	logic        s1_fire;
	logic        in_fire;
	logic        out_valid_q;
	logic [63:0] led_mask_q;
	logic [4:0]  shown_hour_q;
	logic [5:0]  shown_minute_q;
	logic [4:0]  last_hour_q;
	logic [5:0]  last_minute_q;
	logic        frame_valid_q;

	// Handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_fire       = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hour_s1   <= s_axis_tdata[4:0];
			minute_s1 <= s_axis_tdata[10:5];
		end
	end

	// Rounding and mask decode
	wcl_round u_round (
		.hour_raw   (hour_s1),
		.minute_raw (minute_s1),
		.hour       (hour_r),
		.minute     (minute_r)
	);

	wcl_mask u_mask (
		.hour     (hour_r),
		.minute   (minute_r),
		.led_mask (mask_r)
	);

	// Only a changed time makes a frame
	assign emit = !frame_valid_q || (hour_r != last_hour_q) || (minute_r != last_minute_q);

	// Last shown time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hour_q   <= '0;
			last_minute_q <= '0;
			frame_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			last_hour_q   <= hour_r;
			last_minute_q <= minute_r;
			frame_valid_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			led_mask_q     <= mask_r;
			shown_hour_q   <= hour_r;
			shown_minute_q <= minute_r;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, shown_minute_q, shown_hour_q, led_mask_q};

	// Checks
	`WCL_ASSERT_NEXT(a_last_tracks_out, clk, arst_n, s1_fire && emit,
		frame_valid_q && (last_hour_q == shown_hour_q) && (last_minute_q == shown_minute_q))
	`WCL_ASSERT_SAME(a_itis_lit, clk, arst_n, out_valid_q,
		led_mask_q[63] && led_mask_q[62])
	`WCL_ASSERT_SAME(a_to_past_excl, clk, arst_n, out_valid_q && led_mask_q[40],
		!led_mask_q[32] && !led_mask_q[33])
	`WCL_ASSERT_SAME(a_stall_only_full, clk, arst_n, !s_axis_tready,
		s1_valid_q && out_valid_q && !m_axis_tready)

endmodule
